### hdl/masked_pattern_scanner_macros.svh
// Assertion macros used by the checker file.
`ifndef MASKED_PATTERN_SCANNER_MACROS_SVH
`define MASKED_PATTERN_SCANNER_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define MPS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("masked_pattern_scanner: assertion failed");

// Clocked property that also holds through reset.
`define MPS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("masked_pattern_scanner: reset assertion failed");

`endif

### hdl/mps_pkg.sv
package mps_pkg;

    localparam int DEF_PATTERN_MAX = 64;
    localparam int DEF_ADDR_BITS   = 32;

    // field widths
    localparam int OP_W    = 2;
    localparam int IDX_W   = 6;
    localparam int BYTE_W  = 8;
    localparam int ADDR_W  = 32;
    localparam int LEN_W   = 7;
    localparam int ALIGN_W = 13;
    localparam int ENTRY_W = BYTE_W + 1;

    // input tdata layout, lowest bit first
    localparam int IDX_LSB   = 0;
    localparam int PBYTE_LSB = IDX_LSB + IDX_W;
    localparam int CARE_LSB  = PBYTE_LSB + BYTE_W;
    localparam int ADDR_LSB  = CARE_LSB + 1;
    localparam int DBYTE_LSB = ADDR_LSB + ADDR_W;
    localparam int IN_BITS   = DBYTE_LSB + BYTE_W;
    localparam int TDATA_IN_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int TUSER_IN_W  = OP_W;
    localparam int TDATA_OUT_W = ADDR_W;
    localparam int TUSER_OUT_W = 1;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = ALIGN_W;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_STEP  = 2'd1;

    // item kinds
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_SCAN  = 2'd2;

    typedef struct packed {
        logic              care;
        logic [BYTE_W-1:0] pbyte;
    } t_entry;

endpackage

### hdl/mps_rem.sv
module mps_rem #(
    parameter int DIVIDEND_W = mps_pkg::DEF_ADDR_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [DIVIDEND_W-1:0]         i_dividend,
    input  logic [mps_pkg::ALIGN_W-1:0]   i_divisor,
    output logic                          o_done,
    output logic [mps_pkg::ALIGN_W-1:0]   o_rem
);

    localparam int DVW  = mps_pkg::ALIGN_W;
    localparam int CNTW = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] r_div;
    logic [DVW-1:0]        r_rem;
    logic [CNTW-1:0]       r_cnt;
    logic                  r_done;
    logic [DVW:0]          w_trial;
    logic [DVW:0]          w_next;

    // restoring step, one dividend bit per cycle, MSB first
    assign w_trial = {r_rem, r_div[DIVIDEND_W-1]};
    assign w_next  = (w_trial >= {1'b0, i_divisor}) ? (w_trial - {1'b0, i_divisor}) : w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && (r_cnt == CNTW'(1));
            if (i_start) begin
                r_div <= i_dividend;
                r_rem <= '0;
                r_cnt <= CNTW'(DIVIDEND_W);
            end else if (r_cnt != '0) begin
                r_div <= r_div << 1;
                r_rem <= w_next[DVW-1:0];
                r_cnt <= r_cnt - CNTW'(1);
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

### hdl/mps_pat_ram.sv
module mps_pat_ram #(
    parameter int DEPTH = mps_pkg::DEF_PATTERN_MAX,
    parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [IW-1:0]                i_waddr,
    input  logic [mps_pkg::ENTRY_W-1:0]  i_wdata,
    input  logic [IW-1:0]                i_raddr,
    output logic [mps_pkg::ENTRY_W-1:0]  o_rdata
);

    logic [mps_pkg::ENTRY_W-1:0] r_mem [DEPTH];
    logic [mps_pkg::ENTRY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/masked_pattern_scanner.sv
// channel   direction  handshake                      payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tdata item fields, tuser op, tlast last byte
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata match address, tuser found
// cfg       in         i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// Load, start and skipped scan transactions are handled in the idle state; a compared byte
// goes through the registered read of the pattern RAM.
// A mismatch or an aligned full match runs the bit-serial remainder unit once, an unaligned
// full match runs it twice; a result then passes to the output register and is held back
// while the output register is still full.
// Synchronous active-low reset clears control state; the pattern RAM is not cleared.
// Input is taken only when the sequencer is idle; a result waits in the output
// register while further transactions are accepted.
module masked_pattern_scanner #(
    parameter int PATTERN_MAX = mps_pkg::DEF_PATTERN_MAX,
    parameter int ADDR_BITS   = mps_pkg::DEF_ADDR_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // entry_index, pattern_byte, care, address, data_byte, zero pad
    input  logic [mps_pkg::TDATA_IN_W-1:0]     s_axis_tdata,
    // op
    input  logic [mps_pkg::TUSER_IN_W-1:0]     s_axis_tuser,
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // match_address
    output logic [mps_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,
    // found
    output logic [mps_pkg::TUSER_OUT_W-1:0]    m_axis_tuser,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mps_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mps_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int CW  = $clog2(PATTERN_MAX + 1);
    localparam int IW  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int LW  = (CW > mps_pkg::LEN_W) ? CW : mps_pkg::LEN_W;
    localparam int AW  = mps_pkg::ADDR_W;
    localparam int ALW = mps_pkg::ALIGN_W;
    localparam int BW  = mps_pkg::BYTE_W;

    typedef enum logic [2:0] {S_IDLE, S_LOOK, S_CHECK, S_MOVE, S_EMIT} t_state;

    t_state                  r_state;
    logic [mps_pkg::LEN_W-1:0] r_plen;
    logic [ALW-1:0]          r_align;
    logic [CW-1:0]           r_mc;
    logic [CW-1:0]           n_mc;
    logic [ADDR_BITS-1:0]    r_cand;
    logic [ADDR_BITS-1:0]    r_b;
    logic                    r_fin;
    logic [BW-1:0]           r_data;
    logic                    r_last;
    logic                    r_res_found;
    logic [AW-1:0]           r_res_addr;
    logic                    r_out_valid;
    logic                    r_out_found;
    logic [AW-1:0]           r_out_addr;

    logic [mps_pkg::OP_W-1:0]  w_op;
    logic [mps_pkg::IDX_W-1:0] w_eidx;
    logic [BW-1:0]             w_pbyte;
    logic                      w_care;
    logic [ADDR_BITS-1:0]      w_in_addr;
    logic [BW-1:0]             w_dbyte;
    logic                      w_s_acc;
    logic                      w_cfg_len;
    logic                      w_emit;
    logic [LW-1:0]             w_len;
    logic [ALW-1:0]            w_al;
    logic                      w_we;
    logic [mps_pkg::ENTRY_W-1:0] w_rdata;
    mps_pkg::t_entry           w_entry;
    logic                      w_hit;
    logic [CW-1:0]             w_idx_next;
    logic                      w_full;
    logic [CW-1:0]             w_cons;
    logic [ADDR_BITS-1:0]      w_sum;
    logic                      w_rem_start;
    logic [ADDR_BITS-1:0]      w_rem_dividend;
    logic                      w_rem_done;
    logic [ALW-1:0]            w_rem;
    logic [ADDR_BITS-1:0]      w_moved;

    assign w_op      = s_axis_tuser;
    assign w_eidx    = s_axis_tdata[mps_pkg::IDX_LSB +: mps_pkg::IDX_W];
    assign w_pbyte   = s_axis_tdata[mps_pkg::PBYTE_LSB +: BW];
    assign w_care    = s_axis_tdata[mps_pkg::CARE_LSB];
    assign w_in_addr = ADDR_BITS'(s_axis_tdata[mps_pkg::ADDR_LSB +: AW]);
    assign w_dbyte   = s_axis_tdata[mps_pkg::DBYTE_LSB +: BW];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_s_acc       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign w_cfg_len     = i_cfg_valid && (i_cfg_index == mps_pkg::CFG_PATTERN_LEN);
    assign w_emit        = (r_state == S_EMIT) && (!r_out_valid || m_axis_tready);

    always_comb begin
        if (r_plen == '0) begin
            w_len = LW'(1);
        end else if (LW'(r_plen) > LW'(PATTERN_MAX)) begin
            w_len = LW'(PATTERN_MAX);
        end else begin
            w_len = LW'(r_plen);
        end
    end

    assign w_al = (r_align == '0) ? ALW'(1) : r_align;

    assign w_we = w_s_acc && (w_op == mps_pkg::OP_LOAD) && (LW'(w_eidx) < LW'(PATTERN_MAX));

    mps_pat_ram #(
        .DEPTH (PATTERN_MAX),
        .IW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (IW'(w_eidx)),
        .i_wdata ({w_care, w_pbyte}),
        .i_raddr (r_mc[IW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_entry    = mps_pkg::t_entry'(w_rdata);
    assign w_hit      = !w_entry.care || (w_entry.pbyte == r_data);
    assign w_idx_next = r_mc + CW'(1);
    assign w_full     = w_hit && (LW'(w_idx_next) >= w_len);
    assign w_cons     = w_hit ? w_idx_next : r_mc;
    assign w_sum      = r_cand + ADDR_BITS'(w_cons);

    // full match checks the candidate first; a mismatch goes straight to the move
    assign w_rem_start = ((r_state == S_LOOK) && (!w_hit || w_full))
                      || ((r_state == S_CHECK) && w_rem_done && (w_rem != '0));
    assign w_rem_dividend = (r_state == S_LOOK) ? (w_hit ? r_cand : w_sum) : r_b;

    mps_rem #(
        .DIVIDEND_W (ADDR_BITS)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_rem_start),
        .i_dividend (w_rem_dividend),
        .i_divisor  (w_al),
        .o_done     (w_rem_done),
        .o_rem      (w_rem)
    );

    assign w_moved = r_b + ADDR_BITS'(w_al - w_rem);

    // matched count; a pattern length write restarts the partial match
    always_comb begin
        n_mc = r_mc;
        unique case (r_state)
            S_IDLE: begin
                if (w_s_acc && (w_op == mps_pkg::OP_START)) begin
                    n_mc = '0;
                end
            end
            S_LOOK: begin
                if (w_hit && !w_full) begin
                    n_mc = w_idx_next;
                end
            end
            S_CHECK: begin
                if (w_rem_done && (w_rem == '0)) begin
                    n_mc = '0;
                end
            end
            S_MOVE: begin
                if (w_rem_done) begin
                    n_mc = '0;
                end
            end
            default: begin
                n_mc = r_mc;
            end
        endcase
        if (w_cfg_len) begin
            n_mc = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_plen      <= mps_pkg::LEN_W'(1);
            r_align     <= ALW'(1);
            r_mc        <= '0;
            r_cand      <= '0;
            r_fin       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mc <= n_mc;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_s_acc) begin
                        if (w_op == mps_pkg::OP_START) begin
                            r_cand <= w_in_addr;
                            r_fin  <= 1'b0;
                        end else if ((w_op == mps_pkg::OP_SCAN) && !r_fin) begin
                            r_data <= w_dbyte;
                            r_last <= s_axis_tlast;
                            if (w_in_addr >= r_cand) begin
                                r_state <= S_LOOK;
                            end else if (s_axis_tlast) begin
                                r_fin       <= 1'b1;
                                r_res_found <= 1'b0;
                                r_res_addr  <= '0;
                                r_state     <= S_EMIT;
                            end
                        end
                    end
                end
                S_LOOK: begin
                    r_b <= w_sum;
                    if (w_full) begin
                        r_state <= S_CHECK;
                    end else if (!w_hit) begin
                        r_state <= S_MOVE;
                    end else begin
                        if (r_last) begin
                            r_fin       <= 1'b1;
                            r_res_found <= 1'b0;
                            r_res_addr  <= '0;
                            r_state     <= S_EMIT;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_CHECK: begin
                    if (w_rem_done) begin
                        if (w_rem == '0) begin
                            r_fin       <= 1'b1;
                            r_res_found <= 1'b1;
                            r_res_addr  <= AW'(r_cand);
                            r_state     <= S_EMIT;
                        end else begin
                            r_state <= S_MOVE;
                        end
                    end
                end
                S_MOVE: begin
                    if (w_rem_done) begin
                        r_cand <= w_moved;
                        if (r_last) begin
                            r_fin       <= 1'b1;
                            r_res_found <= 1'b0;
                            r_res_addr  <= '0;
                            r_state     <= S_EMIT;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_EMIT: begin
                    if (w_emit) begin
                        r_out_found <= r_res_found;
                        r_out_addr  <= r_res_addr;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (i_cfg_valid) begin
                if (i_cfg_index == mps_pkg::CFG_PATTERN_LEN) begin
                    r_plen <= i_cfg_data[mps_pkg::LEN_W-1:0];
                end else if (i_cfg_index == mps_pkg::CFG_ALIGN_STEP) begin
                    r_align <= i_cfg_data[ALW-1:0];
                end
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_addr;
    assign m_axis_tuser  = r_out_found;

endmodule

### hdl/mps_checker.sv
`include "masked_pattern_scanner_macros.svh"

module mps_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic [mps_pkg::TUSER_IN_W-1:0]     s_axis_tuser,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [mps_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,
    input logic [mps_pkg::TUSER_OUT_W-1:0]    m_axis_tuser
);

    logic w_s_acc;
    logic w_quiet_op;

    assign w_s_acc    = s_axis_tvalid && s_axis_tready;
    assign w_quiet_op = (s_axis_tuser != mps_pkg::OP_SCAN);

    `MPS_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    `MPS_ASSERT(a_not_found_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    `MPS_ASSERT(a_no_result_from_load, i_clk, i_rst_n, w_s_acc && w_quiet_op && !m_axis_tvalid |=> !m_axis_tvalid)
    `MPS_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !m_axis_tvalid)

endmodule

bind masked_pattern_scanner mps_checker u_mps_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### sim/tb_masked_pattern_scanner.sv
`timescale 1ns / 1ps

module tb_masked_pattern_scanner;

    localparam int PATTERN_MAX    = mps_pkg::DEF_PATTERN_MAX;
    localparam int ITEM_TARGET    = 650;
    localparam int PHASE_ITEMS    = 60;
    localparam int SETTLE_CYCLES  = 100;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [mps_pkg::OP_W-1:0]      OP_SPARE   = 2'd3;
    localparam logic [mps_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic                       found;
        logic [mps_pkg::ADDR_W-1:0] addr;
    } t_scan_result;

    class scan_predictor;
        mps_pkg::t_entry             store [PATTERN_MAX];
        logic [mps_pkg::LEN_W-1:0]   pattern_len;
        logic [mps_pkg::ALIGN_W-1:0] align_step;
        int unsigned                 matched;
        logic [mps_pkg::ADDR_W-1:0]  cand;
        bit                          done;
        t_scan_result                pending_results [$];
        int                          mismatches;

        function new();
            foreach (store[i]) store[i] = '0;
            pattern_len = mps_pkg::LEN_W'(1);
            align_step  = mps_pkg::ALIGN_W'(1);
            matched     = 0;
            cand        = '0;
            done        = 0;
            mismatches  = 0;
        endfunction

        function int unsigned eff_len();
            if (pattern_len == 0) return 1;
            if (pattern_len > PATTERN_MAX) return PATTERN_MAX;
            return 32'(pattern_len);
        endfunction

        function int unsigned eff_align();
            return (align_step == 0) ? 1 : 32'(align_step);
        endfunction

        function void advance(int unsigned consumed);
            logic [63:0] b;
            int unsigned al;
            al = eff_align();
            b = ({32'b0, cand} + 64'(consumed)) & 64'hFFFF_FFFF;
            b = (b + (64'(al) - b % 64'(al))) & 64'hFFFF_FFFF;
            cand = b[mps_pkg::ADDR_W-1:0];
            matched = 0;
        endfunction

        function void write_reg(logic [mps_pkg::CFG_IDX_W-1:0] idx,
                                logic [mps_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                mps_pkg::CFG_PATTERN_LEN: begin
                    pattern_len = data[mps_pkg::LEN_W-1:0];
                    matched = 0;
                end
                mps_pkg::CFG_ALIGN_STEP: align_step = data;
                default: ;
            endcase
        endfunction

        function void take_item(logic [mps_pkg::OP_W-1:0] op,
                                logic [mps_pkg::IDX_W-1:0] idx,
                                logic [mps_pkg::BYTE_W-1:0] pbyte, logic care,
                                logic [mps_pkg::ADDR_W-1:0] addr,
                                logic [mps_pkg::BYTE_W-1:0] dbyte, logic last);
            mps_pkg::t_entry e;
            int unsigned     nxt;
            case (op)
                mps_pkg::OP_LOAD:  store[idx] = '{care: care, pbyte: pbyte};
                mps_pkg::OP_START: begin
                    cand = addr;
                    matched = 0;
                    done = 0;
                end
                mps_pkg::OP_SCAN: begin
                    if (done) return;
                    if (addr >= cand) begin
                        e = store[matched];
                        if (!e.care || e.pbyte == dbyte) begin
                            nxt = matched + 1;
                            if (nxt >= eff_len()) begin
                                if (cand % eff_align() == 0) begin
                                    done = 1;
                                    matched = 0;
                                    pending_results.push_back('{found: 1'b1, addr: cand});
                                    return;
                                end
                                advance(nxt);
                            end else begin
                                matched = nxt;
                            end
                        end else begin
                            advance(matched);
                        end
                    end
                    if (last) begin
                        done = 1;
                        pending_results.push_back('{found: 1'b0, addr: '0});
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic found, logic [mps_pkg::ADDR_W-1:0] addr);
            t_scan_result exp_res;
            if (pending_results.size() == 0) begin
                $error("unexpected result: found %0d, match_address 0x%08h", found, addr);
                mismatches++;
                return;
            end
            exp_res = pending_results.pop_front();
            if (found !== exp_res.found) begin
                $error("found: expected %0d, actual %0d", exp_res.found, found);
                mismatches++;
            end
            if (addr !== exp_res.addr) begin
                $error("match_address: expected 0x%08h, actual 0x%08h", exp_res.addr, addr);
                mismatches++;
            end
        endfunction
    endclass

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    // entry_index, pattern_byte, care, address, data_byte, zero pad
    logic [mps_pkg::TDATA_IN_W-1:0]      s_axis_tdata = '0;
    // op
    logic [mps_pkg::TUSER_IN_W-1:0]      s_axis_tuser = '0;
    logic                                s_axis_tlast = 1'b0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    // match_address
    logic [mps_pkg::TDATA_OUT_W-1:0]     m_axis_tdata;
    // found
    logic [mps_pkg::TUSER_OUT_W-1:0]     m_axis_tuser;
    logic                                i_cfg_valid = 1'b0;
    logic                                o_cfg_ready;
    logic [mps_pkg::CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [mps_pkg::CFG_DATA_W-1:0]      i_cfg_data = '0;

    scan_predictor tracker;
    int items_sent = 0;
    int send_gap_max = 8;
    int recv_stall_max = 8;
    int idle_cycles = 0;
    int len_set [10] = '{3, 1, 64, 0, 2, 5, 127, 4, 8, 16};
    int align_set [10] = '{1, 4, 0, 4096, 2, 3, 8, 1, 16, 7};

    masked_pattern_scanner uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // called at a falling edge; returns at the falling edge after the handshake, tvalid still high
    task automatic send_item(input logic [mps_pkg::OP_W-1:0] op,
                             input logic [mps_pkg::IDX_W-1:0] idx,
                             input logic [mps_pkg::BYTE_W-1:0] pbyte, input logic care,
                             input logic [mps_pkg::ADDR_W-1:0] addr,
                             input logic [mps_pkg::BYTE_W-1:0] dbyte, input logic last);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata = '0;
        s_axis_tdata[mps_pkg::IDX_LSB +: mps_pkg::IDX_W]    = idx;
        s_axis_tdata[mps_pkg::PBYTE_LSB +: mps_pkg::BYTE_W] = pbyte;
        s_axis_tdata[mps_pkg::CARE_LSB]                     = care;
        s_axis_tdata[mps_pkg::ADDR_LSB +: mps_pkg::ADDR_W]  = addr;
        s_axis_tdata[mps_pkg::DBYTE_LSB +: mps_pkg::BYTE_W] = dbyte;
        s_axis_tuser  = op;
        s_axis_tlast  = last;
        s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        tracker.take_item(op, idx, pbyte, care, addr, dbyte, last);
        items_sent++;
        @(negedge i_clk);
    endtask

    // one transaction with every field random
    task automatic send_random();
        send_item(mps_pkg::OP_W'($urandom_range(0, 3)), mps_pkg::IDX_W'($urandom),
                  mps_pkg::BYTE_W'($urandom), 1'($urandom), $urandom,
                  mps_pkg::BYTE_W'($urandom), 1'($urandom));
    endtask

    task automatic write_reg(input logic [mps_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mps_pkg::CFG_DATA_W-1:0] data,
                             input bit final_write);
        s_axis_tvalid = 1'b0;
        i_cfg_index = idx;
        i_cfg_data  = data;
        i_cfg_valid = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tracker.write_reg(idx, data);
        @(negedge i_clk);
        if (final_write) i_cfg_valid = 1'b0;
    endtask

    task automatic drain_results();
        s_axis_tvalid = 1'b0;
        while (tracker.pending_results.size() != 0) @(negedge i_clk);
    endtask

    // results drained, then room for a trailing remainder computation
    task automatic wait_idle();
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // stream with a planted pattern copy at an aligned address, plus near misses
    task automatic scan_sequence();
        int unsigned                 len;
        int unsigned                 al;
        int unsigned                 off;
        int unsigned                 skip;
        int unsigned                 n;
        logic [mps_pkg::ADDR_W-1:0]  a_match;
        logic [mps_pkg::ADDR_W-1:0]  addr;
        logic [mps_pkg::ADDR_W-1:0]  pos;
        logic [mps_pkg::BYTE_W-1:0]  dbyte;
        logic                        last;
        logic [mps_pkg::IDX_W-1:0]   j_idx;
        logic [mps_pkg::BYTE_W-1:0]  j_pbyte;
        logic                        j_care;
        len = tracker.eff_len();
        al  = tracker.eff_align();
        a_match = ($urandom / al) * al;
        if ($urandom_range(0, 7) == 0) a_match = (32'hFFFF_FFFF / al) * al;
        off  = $urandom_range(0, 7);
        skip = $urandom_range(0, 2);
        n    = skip + off + len + $urandom_range(0, 3);
        if ($urandom_range(0, 9) != 0) begin
            j_idx   = mps_pkg::IDX_W'($urandom);
            j_pbyte = mps_pkg::BYTE_W'($urandom);
            j_care  = 1'($urandom);
            send_item(mps_pkg::OP_START, j_idx, j_pbyte, j_care, a_match - off,
                      mps_pkg::BYTE_W'($urandom), 1'($urandom));
        end
        addr = a_match - off - skip;
        for (int unsigned i = 0; i < n; i++) begin
            pos = addr - a_match;
            if (pos < len) begin
                dbyte = tracker.store[pos[mps_pkg::IDX_W-1:0]].care ?
                        tracker.store[pos[mps_pkg::IDX_W-1:0]].pbyte :
                        mps_pkg::BYTE_W'($urandom);
                if ($urandom_range(0, 4 * len) == 0) dbyte = mps_pkg::BYTE_W'($urandom);
            end else if ($urandom_range(0, 3) == 0) begin
                dbyte = tracker.store[0].pbyte;
            end else begin
                dbyte = mps_pkg::BYTE_W'($urandom);
            end
            last = (i == n - 1) || ($urandom_range(0, 40) == 0);
            j_idx   = mps_pkg::IDX_W'($urandom);
            j_pbyte = mps_pkg::BYTE_W'($urandom);
            j_care  = 1'($urandom);
            send_item(mps_pkg::OP_SCAN, j_idx, j_pbyte, j_care, addr, dbyte, last);
            if ($urandom_range(0, 15) == 0) addr = addr + $urandom_range(2, 5);
            else addr = addr + 1;
        end
    endtask

    initial begin : result_sink
        int stall;
        @(posedge i_rst_n);
        forever begin
            stall = $urandom_range(0, recv_stall_max);
            if (stall > 0) begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            tracker.check_result(m_axis_tuser[0], m_axis_tdata);
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        int phase;
        int phase_start;
        int len_cfg;
        int align_cfg;
        tracker = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // scan before any start, result then an ignored byte, unused op
        send_item(mps_pkg::OP_LOAD, 6'd0, 8'hA5, 1'b1, '0, '0, 1'b0);
        send_item(mps_pkg::OP_SCAN, '0, '0, 1'b0, 32'h0, 8'h00, 1'b0);
        send_item(mps_pkg::OP_SCAN, '0, '0, 1'b0, 32'h1, 8'hA5, 1'b0);
        send_item(mps_pkg::OP_SCAN, '0, '0, 1'b0, 32'h2, 8'hA5, 1'b1);
        send_item(OP_SPARE, 6'h3F, 8'hFF, 1'b1, 32'hFFFF_FFFF, 8'hFF, 1'b1);
        wait_idle();
        write_reg(mps_pkg::CFG_PATTERN_LEN, 13'd4, 1'b0);
        write_reg(mps_pkg::CFG_ALIGN_STEP, 13'd4, 1'b1);
        send_item(mps_pkg::OP_LOAD, 6'd0, 8'h00, 1'b1, '0, '0, 1'b0);
        send_item(mps_pkg::OP_LOAD, 6'd1, 8'hFF, 1'b0, '0, '0, 1'b0);
        send_item(mps_pkg::OP_LOAD, 6'd2, 8'hFF, 1'b1, '0, '0, 1'b0);
        send_item(mps_pkg::OP_LOAD, 6'd3, 8'h12, 1'b1, '0, '0, 1'b0);
        // mismatch near the top wraps the candidate to zero; address gap after it
        send_item(mps_pkg::OP_START, '0, '0, 1'b0, 32'hFFFF_FFFD, '0, 1'b0);
        send_item(mps_pkg::OP_SCAN, '0, '0, 1'b0, 32'hFFFF_FFFD, 8'h55, 1'b0);
        send_item(mps_pkg::OP_SCAN, '0, '0, 1'b0, 32'h10, 8'h00, 1'b0);
        send_item(mps_pkg::OP_SCAN, '0, '0, 1'b0, 32'h11, 8'hAB, 1'b0);
        send_item(mps_pkg::OP_SCAN, '0, '0, 1'b0, 32'h12, 8'hFF, 1'b0);
        send_item(mps_pkg::OP_SCAN, '0, '0, 1'b0, 32'h13, 8'h12, 1'b1);
        // length rewrite mid-match restarts at the same candidate
        send_item(mps_pkg::OP_START, '0, '0, 1'b0, 32'h100, '0, 1'b0);
        send_item(mps_pkg::OP_SCAN, '0, '0, 1'b0, 32'h100, 8'h00, 1'b0);
        send_item(mps_pkg::OP_SCAN, '0, '0, 1'b0, 32'h101, 8'h99, 1'b0);
        wait_idle();
        write_reg(mps_pkg::CFG_PATTERN_LEN, 13'd2, 1'b1);
        send_item(mps_pkg::OP_SCAN, '0, '0, 1'b0, 32'h102, 8'h00, 1'b0);
        send_item(mps_pkg::OP_SCAN, '0, '0, 1'b0, 32'h103, 8'h42, 1'b0);
        // unaligned full match moves on; last byte then falls below the start
        send_item(mps_pkg::OP_START, '0, '0, 1'b0, 32'h1, '0, 1'b0);
        send_item(mps_pkg::OP_SCAN, '0, '0, 1'b0, 32'h1, 8'h00, 1'b0);
        send_item(mps_pkg::OP_SCAN, '0, '0, 1'b0, 32'h2, 8'h77, 1'b0);
        send_item(mps_pkg::OP_SCAN, '0, '0, 1'b0, 32'h3, 8'h00, 1'b1);

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            wait_idle();
            if (phase < 10) begin
                len_cfg   = len_set[phase];
                align_cfg = align_set[phase];
            end else begin
                len_cfg   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) :
                            $urandom_range(1, 8);
                align_cfg = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4096) :
                            $urandom_range(1, 8);
            end
            write_reg(mps_pkg::CFG_PATTERN_LEN, mps_pkg::CFG_DATA_W'(len_cfg), 1'b0);
            if (phase % 5 == 2)
                write_reg(CFG_UNUSED, mps_pkg::CFG_DATA_W'($urandom), 1'b0);
            write_reg(mps_pkg::CFG_ALIGN_STEP, mps_pkg::CFG_DATA_W'(align_cfg), 1'b1);
            send_gap_max   = (phase % 3 == 1) ? 0 : 8;
            recv_stall_max = (phase % 4 == 2) ? 0 : 8;
            if (phase == 0) begin
                for (int i = 0; i < PATTERN_MAX; i++)
                    send_item(mps_pkg::OP_LOAD, mps_pkg::IDX_W'(i),
                              mps_pkg::BYTE_W'($urandom), $urandom_range(0, 3) != 0,
                              $urandom, mps_pkg::BYTE_W'($urandom), 1'($urandom));
            end
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) == 0) drain_results();
                if ($urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(1, 3)) send_random();
                end
                scan_sequence();
            end
            phase++;
        end

        wait_idle();
        if (tracker.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### masked_pattern_scanner.f
+incdir+hdl
hdl/mps_pkg.sv
hdl/mps_rem.sv
hdl/mps_pat_ram.sv
hdl/masked_pattern_scanner.sv
hdl/mps_checker.sv
sim/tb_masked_pattern_scanner.sv
